FILE: hw/rtl/vrpa_pkg.sv
package vrpa_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 20;
  localparam int Guard       = 28;
  localparam int StepW       = $clog2(CordicSteps);

  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic [63:0] Pico = 64'd1000000000000;

  localparam logic signed [31:0] FullTurn = 32'sd360 <<< FracBits;
  localparam logic signed [31:0] HalfTurn = 32'sd180 <<< FracBits;
  localparam logic signed [31:0] QuarterTurn = 32'sd90 <<< FracBits;
  localparam logic signed [31:0] AngMax = 32'sd33554431;

  // number of compare-subtract steps for the modulo-360 reduction
  localparam int RedSteps = 7;

  localparam logic [2:0] CmdLoadRect  = 3'd0;
  localparam logic [2:0] CmdLoadPolar = 3'd1;
  localparam logic [2:0] CmdAdd       = 3'd2;
  localparam logic [2:0] CmdSub       = 3'd3;
  localparam logic [2:0] CmdNegate    = 3'd4;
  localparam logic [2:0] CmdScale     = 3'd5;

  // arctangent of 2^-i in units of 1e-12 degree
  localparam logic [63:0] AtanPico [31] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997, 64'd1789910608246, 64'd895173710211, 64'd447614170861,
    64'd223810500369, 64'd111905677066, 64'd55952891894, 64'd27976452617,
    64'd13988227142, 64'd6994113675, 64'd3497056851, 64'd1748528427,
    64'd874264214, 64'd437132107, 64'd218566053, 64'd109283027,
    64'd54641513, 64'd27320757, 64'd13660378, 64'd6830189,
    64'd3415095, 64'd1707547, 64'd853774, 64'd426887,
    64'd213443, 64'd106722, 64'd53361
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_MULX,
    OP_MULY,
    OP_SCALEY,
    OP_VINIT,
    OP_VITER,
    OP_VGHI,
    OP_VGLO,
    OP_VFIN,
    OP_RED,
    OP_PGHI,
    OP_PGLO,
    OP_RINIT,
    OP_RITER
  } vrpa_op_e;

  typedef struct packed {
    vrpa_op_e         op;
    logic [StepW-1:0] step;
    logic             fin_rot;
    logic             clear;
    logic             publish;
  } vrpa_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       mag_nonpos;
    logic       is_zero;
  } vrpa_sts_t;

  // atan(2^-i) in degrees, Q(FracBits), rounded
  function automatic logic signed [31:0] atan_fix(int i);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    v = AtanPico[i];
    q = v / Pico;
    r = v % Pico;
    return 32'((q << FracBits) + ((r << FracBits) + Pico / 2) / Pico);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [25:0] sat_angle(logic signed [31:0] v);
    if (v > AngMax) return 26'(AngMax);
    if (v < -AngMax) return 26'(-AngMax);
    return v[25:0];
  endfunction

endpackage

FILE: hw/rtl/vrpa_ctrl.sv
module vrpa_ctrl import vrpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  vrpa_sts_t sts_i,
  output vrpa_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PREP, S_MULX, S_MULY, S_SCALEY, S_VINIT, S_VITER,
    S_VGHI, S_VGLO, S_VFIN, S_RED, S_PGHI, S_PGLO, S_RINIT, S_RITER, S_RFIN,
    S_CLEAR, S_OUT
  } state_e;

  localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);
  localparam logic [StepW-1:0] RedTop   = StepW'(RedSteps - 1);

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             accept;
  logic             out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // result leaves on an unstalled edge; a new one is shown from S_OUT
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if ((state_q == S_OUT) && out_free) out_valid_d = 1'b1;
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.step    = step_q;
    unique case (state_q)
      S_IDLE:     cmd_o.op = accept ? OP_LOAD : OP_NONE;
      S_PREP:     cmd_o.op = OP_PREP;
      S_MULX:     cmd_o.op = OP_MULX;
      S_MULY:     cmd_o.op = OP_MULY;
      S_SCALEY:   cmd_o.op = OP_SCALEY;
      S_VINIT:    cmd_o.op = OP_VINIT;
      S_VITER:    cmd_o.op = OP_VITER;
      S_VGHI:     cmd_o.op = OP_VGHI;
      S_VGLO:     cmd_o.op = OP_VGLO;
      S_VFIN:     cmd_o.op = OP_VFIN;
      S_RED:      cmd_o.op = OP_RED;
      S_PGHI:     cmd_o.op = OP_PGHI;
      S_PGLO:     cmd_o.op = OP_PGLO;
      S_RINIT:    cmd_o.op = OP_RINIT;
      S_RITER:    cmd_o.op = OP_RITER;
      S_RFIN:     cmd_o.fin_rot = 1'b1;
      S_CLEAR:    cmd_o.clear = 1'b1;
      S_OUT:      cmd_o.publish = out_free;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE:     if (accept) state_q <= S_DISPATCH;
        S_DISPATCH: begin
          priority case (sts_i.cmd)
            CmdLoadRect, CmdAdd, CmdSub, CmdNegate: state_q <= S_PREP;
            CmdLoadPolar: begin
              step_q  <= RedTop;
              state_q <= sts_i.mag_nonpos ? S_CLEAR : S_RED;
            end
            CmdScale: state_q <= S_MULX;
            default:  state_q <= S_CLEAR;
          endcase
        end
        S_PREP:   state_q <= S_VINIT;
        S_MULX:   state_q <= S_MULY;
        S_MULY:   state_q <= S_SCALEY;
        S_SCALEY: state_q <= S_VINIT;
        S_VINIT:  begin
          step_q  <= '0;
          state_q <= sts_i.is_zero ? S_VFIN : S_VITER;
        end
        S_VITER: begin
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) state_q <= S_VGHI;
        end
        S_VGHI: state_q <= S_VGLO;
        S_VGLO: state_q <= S_VFIN;
        S_VFIN: state_q <= S_OUT;
        S_RED: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) state_q <= S_PGHI;
        end
        S_PGHI: state_q <= S_PGLO;
        S_PGLO: state_q <= S_RINIT;
        S_RINIT: begin
          step_q  <= '0;
          state_q <= S_RITER;
        end
        S_RITER: begin
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) state_q <= S_RFIN;
        end
        S_RFIN:  state_q <= S_OUT;
        S_CLEAR: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result shown outside publish state");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VITER || state_q == S_RITER) |-> step_q <= LastStep)
    else $error("iteration index out of range");

endmodule

FILE: hw/rtl/vrpa_datapath.sv
module vrpa_datapath import vrpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrpa_cmd_t           cmd_i,
  input  logic [2:0]          command_i,
  input  logic signed [31:0]  first_operand_i,
  input  logic signed [31:0]  second_operand_i,
  output vrpa_sts_t           sts_o,
  output logic signed [31:0]  x_out_o,
  output logic signed [31:0]  y_out_o,
  output logic [30:0]         magnitude_out_o,
  output logic signed [25:0]  angle_out_o,
  output logic                bad_command_o
);

  logic [2:0]         cmd_q;
  logic signed [31:0] a_q, b_q;
  logic signed [31:0] vec_x_q, vec_y_q;
  logic [30:0]        mag_q;
  logic signed [25:0] ang_q;
  logic signed [31:0] nx_q, ny_q;
  logic signed [63:0] cx_q, cy_q;
  logic signed [31:0] z_q, rr_q;
  logic signed [63:0] prod_q;
  logic [63:0]        acc_q;
  logic [31:0]        am_q;
  logic               neg_q, zero_q;
  logic signed [31:0] xo_q, yo_q;
  logic [30:0]        mo_q;
  logic signed [25:0] ao_q;
  logic               bad_q, bo_q;

  logic signed [31:0] atan_tab [CordicSteps];
  for (genvar g = 0; g < CordicSteps; g++) begin : g_atan
    assign atan_tab[g] = atan_fix(g);
  end

  // shared multiplier: scale products and the CORDIC gain correction
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic [63:0]        gain_u;
  logic [63:0]        pol_u;

  assign gain_u = cx_q[63] ? 64'd0 : 64'(cx_q);
  assign pol_u  = {5'd0, a_q[30:0], 28'd0};

  always_comb begin
    mul_a = 33'(vec_x_q);
    mul_b = GainQ30;
    unique case (cmd_i.op)
      OP_MULX: begin mul_a = 33'(vec_x_q); mul_b = a_q; end
      OP_MULY: begin mul_a = 33'(vec_y_q); mul_b = a_q; end
      OP_VGHI: mul_a = $signed({1'b0, gain_u[61:30]});
      OP_VGLO: mul_a = $signed({3'b0, gain_u[29:0]});
      OP_PGHI: mul_a = $signed({1'b0, pol_u[61:30]});
      OP_PGLO: mul_a = $signed({3'b0, pol_u[29:0]});
      default: mul_a = 33'(vec_x_q);
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [31:0] atan_i;
  logic signed [63:0] cx_sh, cy_sh;
  logic signed [63:0] rnd_prod;
  logic [31:0]        red_sub;
  logic signed [31:0] r_raw, r_adj;
  logic [63:0]        m_full;

  assign atan_i   = atan_tab[cmd_i.step];
  assign cx_sh    = cx_q >>> cmd_i.step;
  assign cy_sh    = cy_q >>> cmd_i.step;
  assign rnd_prod = (prod_q + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  assign red_sub  = 32'(FullTurn) << cmd_i.step;
  assign r_raw    = neg_q ? -$signed(am_q) : $signed(am_q);
  assign m_full   = (acc_q + (64'd1 << (Guard - 1))) >> Guard;

  always_comb begin
    r_adj = r_raw;
    if (r_raw > HalfTurn) r_adj = r_raw - FullTurn;
    else if (r_raw <= -HalfTurn) r_adj = r_raw + FullTurn;
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.mag_nonpos = (a_q <= 32'sd0);
  assign sts_o.is_zero    = (nx_q == '0) && (ny_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_x_q <= '0;
      vec_y_q <= '0;
      mag_q   <= '0;
      ang_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LOAD) bad_q <= 1'b0;
      if (cmd_i.op == OP_VFIN) begin
        vec_x_q <= nx_q;
        vec_y_q <= ny_q;
        if (zero_q) begin
          mag_q <= '0;
          ang_q <= '0;
        end else begin
          mag_q <= (m_full > 64'd2147483647) ? 31'h7fffffff : m_full[30:0];
          ang_q <= sat_angle(z_q);
        end
      end
      if (cmd_i.fin_rot) begin
        vec_x_q <= sat32((cx_q + (64'sd1 <<< (Guard - 1))) >>> Guard);
        vec_y_q <= sat32((cy_q + (64'sd1 <<< (Guard - 1))) >>> Guard);
        mag_q   <= a_q[30:0];
        ang_q   <= sat_angle(rr_q);
      end
      if (cmd_i.clear) begin
        vec_x_q <= '0;
        vec_y_q <= '0;
        mag_q   <= '0;
        ang_q   <= '0;
        bad_q   <= (cmd_q > CmdScale);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= command_i;
        a_q   <= first_operand_i;
        b_q   <= second_operand_i;
        neg_q <= second_operand_i[31];
        am_q  <= second_operand_i[31] ? 32'(-second_operand_i) : 32'(second_operand_i);
      end
      OP_PREP: begin
        priority case (cmd_q)
          CmdAdd: begin
            nx_q <= sat32(64'(33'(vec_x_q) + 33'(a_q)));
            ny_q <= sat32(64'(33'(vec_y_q) + 33'(b_q)));
          end
          CmdSub: begin
            nx_q <= sat32(64'(33'(vec_x_q) - 33'(a_q)));
            ny_q <= sat32(64'(33'(vec_y_q) - 33'(b_q)));
          end
          CmdNegate: begin
            nx_q <= sat32(64'(33'sd0 - 33'(vec_x_q)));
            ny_q <= sat32(64'(33'sd0 - 33'(vec_y_q)));
          end
          default: begin
            nx_q <= a_q;
            ny_q <= b_q;
          end
        endcase
      end
      OP_MULX: prod_q <= mul_p[63:0];
      OP_MULY: begin
        nx_q   <= sat32(rnd_prod);
        prod_q <= mul_p[63:0];
      end
      OP_SCALEY: ny_q <= sat32(rnd_prod);
      OP_VINIT: begin
        zero_q <= (nx_q == '0) && (ny_q == '0);
        if (nx_q[31]) begin
          cx_q <= -(64'(nx_q) <<< Guard);
          cy_q <= -(64'(ny_q) <<< Guard);
          z_q  <= ny_q[31] ? -HalfTurn : HalfTurn;
        end else begin
          cx_q <= 64'(nx_q) <<< Guard;
          cy_q <= 64'(ny_q) <<< Guard;
          z_q  <= '0;
        end
      end
      OP_VITER: begin
        if (cy_q > 64'sd0) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          z_q  <= z_q + atan_i;
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          z_q  <= z_q - atan_i;
        end
      end
      OP_VGHI, OP_PGHI: acc_q <= mul_p[63:0];
      OP_VGLO, OP_PGLO: acc_q <= acc_q + {30'd0, mul_p[63:30]};
      OP_RED: if (am_q >= red_sub) am_q <= am_q - red_sub;
      OP_RINIT: begin
        rr_q <= r_adj;
        cy_q <= '0;
        if (r_adj > QuarterTurn) begin
          cx_q <= -$signed(acc_q);
          z_q  <= r_adj - HalfTurn;
        end else if (r_adj < -QuarterTurn) begin
          cx_q <= -$signed(acc_q);
          z_q  <= r_adj + HalfTurn;
        end else begin
          cx_q <= $signed(acc_q);
          z_q  <= r_adj;
        end
      end
      OP_RITER: begin
        if (!z_q[31]) begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          z_q  <= z_q - atan_i;
        end else begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          z_q  <= z_q + atan_i;
        end
      end
      default: ;
    endcase
    if (cmd_i.publish) begin
      xo_q <= vec_x_q;
      yo_q <= vec_y_q;
      mo_q <= mag_q;
      ao_q <= ang_q;
      bo_q <= bad_q;
    end
  end

  assign x_out_o         = xo_q;
  assign y_out_o         = yo_q;
  assign magnitude_out_o = mo_q;
  assign angle_out_o     = ao_q;
  assign bad_command_o   = bo_q;

endmodule

FILE: hw/rtl/vector_rect_polar_accumulator.sv
// Holds one 2-D vector in Q16.16 and updates it per command: load rect, load polar
// (magnitude, degrees), add, subtract, negate, scale; every item yields one result with
// x, y, magnitude, angle (degrees, in (-180, 180]) and a bad-command flag. Items are
// processed one at a time: a rectangular-family command (a scale after two multiplier
// passes for x and y) or a polar load runs the 20-iteration CORDIC loop that one
// shared shift-add unit runs one step per cycle, plus a 7-step modulo-360 reduction for
// polar loads and two passes through one 33x32 multiplier for gain correction. Invalid
// commands and non-positive polar magnitudes skip all of these; a command that leaves the
// zero vector skips the CORDIC loop and gain correction. A stalled earlier result
// holds the block in its publish state until that result leaves. The result sits in
// an output register, so the next item is taken while a result is still waiting.
module vector_rect_polar_accumulator import vrpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] first_operand_i,
  input  logic signed [31:0] second_operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic [30:0]        magnitude_out_o,
  output logic signed [25:0] angle_out_o,
  output logic               bad_command_o
);

  vrpa_cmd_t dp_cmd;
  vrpa_sts_t dp_sts;

  // sequencer: dispatch, iteration counts, output handshake
  vrpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // vector state, CORDIC unit, multiplier, result register
  vrpa_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .command_i        (command_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .sts_o            (dp_sts),
    .x_out_o          (x_out_o),
    .y_out_o          (y_out_o),
    .magnitude_out_o  (magnitude_out_o),
    .angle_out_o      (angle_out_o),
    .bad_command_o    (bad_command_o)
  );

endmodule

FILE: tb/vector_rect_polar_accumulator_tb.sv
`timescale 1ns / 1ps

module vector_rect_polar_accumulator_tb;
  import vrpa_pkg::*;

  // Pending result of one command
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        mag;
    logic signed [25:0] ang;
    logic               bad;
  } vec_result_t;

  // One directed row; has_exp marks rows whose result is typed in by hand
  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 has_exp;
    vec_result_t        res;
  } cmd_row_t;

  localparam logic [2:0] CmdBadLow  = 3'd6;
  localparam logic [2:0] CmdBadHigh = 3'd7;
  localparam int         GuardBits  = 28;
  localparam int         NumSteps   = 20;
  localparam longint     PicoDeg    = 64'd1000000000000;
  localparam longint     GainK      = 652032874;
  localparam longint     AngLimit   = 33554431;
  localparam longint     Deg180     = 180 * 65536;
  localparam longint     Deg90      = 90 * 65536;
  localparam longint     Deg360     = 360 * 65536;
  localparam int         NumRandom  = 380;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = '0;
  logic signed [31:0] first_operand_i = '0;
  logic signed [31:0] second_operand_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] x_out_o;
  logic signed [31:0] y_out_o;
  logic [30:0]        magnitude_out_o;
  logic signed [25:0] angle_out_o;
  logic               bad_command_o;

  vector_rect_polar_accumulator dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [31:0] cur_x, cur_y;
  logic [31:0]        cur_mag;
  logic signed [31:0] cur_ang;

  vec_result_t pending_q[$];
  vec_result_t hand_q[$];
  bit          hand_valid_q[$];
  int  mismatches = 0;
  bit  quiet = 0;        // no idling in the last stretch
  bit  stim_done = 0;
  longint atan_tab[31];

  function automatic longint ashr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_pico_val(int i);
    return AtanPico[i];
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_ang(longint v);
    if (v > AngLimit) return AngLimit;
    if (v < -AngLimit) return -AngLimit;
    return v;
  endfunction

  // (u * gain) >> 30 without overflowing 64 bits
  function automatic longint gain_mul(longint unsigned u);
    longint unsigned hi, lo;
    hi = u >> 30;
    lo = u & 64'h3fffffff;
    return hi * GainK + ((lo * GainK) >> 30);
  endfunction

  // Vectoring: set x/y, derive magnitude and angle
  task automatic set_rect(longint x, longint y);
    longint cx, cy, z, nx, ny;
    longint unsigned m;
    cur_x = 32'(x);
    cur_y = 32'(y);
    if (x == 0 && y == 0) begin
      cur_mag = 0;
      cur_ang = 0;
      return;
    end
    z = 0;
    cx = x <<< GuardBits;
    cy = y <<< GuardBits;
    if (cx < 0) begin
      z = (y >= 0) ? Deg180 : -Deg180;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < NumSteps; i++) begin
      if (cy > 0) begin
        nx = cx + ashr(cy, i);
        ny = cy - ashr(cx, i);
        z += atan_tab[i];
      end else begin
        nx = cx - ashr(cy, i);
        ny = cy + ashr(cx, i);
        z -= atan_tab[i];
      end
      cx = nx;
      cy = ny;
    end
    m = (gain_mul(cx < 0 ? 0 : cx) + (64'd1 << (GuardBits - 1))) >> GuardBits;
    cur_mag = (m > 2147483647) ? 32'h7fffffff : 32'(m);
    cur_ang = 32'(clamp_ang(z));
  endtask

  // Rotation: magnitude and degrees to x/y
  task automatic set_polar(longint mag, longint ang);
    longint r, cx, cy, z, nx, ny;
    if (mag <= 0) begin
      cur_x = 0; cur_y = 0; cur_mag = 0; cur_ang = 0;
      return;
    end
    r = ang % Deg360;
    if (r > Deg180) r -= Deg360;
    if (r <= -Deg180) r += Deg360;
    cx = gain_mul(mag << GuardBits);
    cy = 0;
    z = r;
    if (r > Deg90) begin
      cx = -cx; z = r - Deg180;
    end else if (r < -Deg90) begin
      cx = -cx; z = r + Deg180;
    end
    for (int i = 0; i < NumSteps; i++) begin
      if (z >= 0) begin
        nx = cx - ashr(cy, i);
        ny = cy + ashr(cx, i);
        z -= atan_tab[i];
      end else begin
        nx = cx + ashr(cy, i);
        ny = cy - ashr(cx, i);
        z += atan_tab[i];
      end
      cx = nx;
      cy = ny;
    end
    cur_x = 32'(clamp32(ashr(cx + (64'sd1 <<< (GuardBits - 1)), GuardBits)));
    cur_y = 32'(clamp32(ashr(cy + (64'sd1 <<< (GuardBits - 1)), GuardBits)));
    cur_mag = 32'(mag);
    cur_ang = 32'(clamp_ang(r));
  endtask

  function automatic longint scale_part(longint v, longint f);
    return clamp32(ashr(v * f + 32768, 16));
  endfunction

  // Applies one command to the predictor, returns the expected result
  task automatic apply_command(input logic [2:0] cmd, input logic signed [31:0] a,
                               input logic signed [31:0] b, output vec_result_t res);
    longint la, lb;
    la = longint'(a);
    lb = longint'(b);
    res.bad = 1'b0;
    case (cmd)
      CmdLoadRect:  set_rect(la, lb);
      CmdLoadPolar: set_polar(la, lb);
      CmdAdd:       set_rect(clamp32(cur_x + la), clamp32(cur_y + lb));
      CmdSub:       set_rect(clamp32(cur_x - la), clamp32(cur_y - lb));
      CmdNegate:    set_rect(clamp32(-longint'(cur_x)), clamp32(-longint'(cur_y)));
      CmdScale:     set_rect(scale_part(longint'(cur_x), la),
                             scale_part(longint'(cur_y), la));
      default: begin
        cur_x = 0; cur_y = 0; cur_mag = 0; cur_ang = 0;
        res.bad = 1'b1;
      end
    endcase
    res.x = cur_x;
    res.y = cur_y;
    res.mag = cur_mag[30:0];
    res.ang = cur_ang[25:0];
  endtask

  function automatic vec_result_t mk(longint x, longint y, longint m, longint g, bit bad);
    vec_result_t r;
    r.x = 32'(x); r.y = 32'(y); r.mag = 31'(m); r.ang = 26'(g); r.bad = bad;
    return r;
  endfunction

  function automatic cmd_row_t row(logic [2:0] c, logic signed [31:0] a,
                                   logic signed [31:0] b);
    cmd_row_t t;
    t.cmd = c; t.a = a; t.b = b; t.has_exp = 1'b0; t.res = mk(0, 0, 0, 0, 0);
    return t;
  endfunction

  function automatic cmd_row_t row_exp(logic [2:0] c, logic signed [31:0] a,
                                       logic signed [31:0] b, vec_result_t r);
    cmd_row_t t;
    t = row(c, a, b);
    t.has_exp = 1'b1;
    t.res = r;
    return t;
  endfunction

  // Idle burst: drop valid, then wait
  task automatic random_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // Present one command and hold it until accepted
  task automatic send_command(logic [2:0] c, logic signed [31:0] a, logic signed [31:0] b,
                              bit has_exp, vec_result_t hand);
    vec_result_t res;
    random_gap();
    apply_command(c, a, b, res);
    pending_q.push_back(res);
    hand_q.push_back(hand);
    hand_valid_q.push_back(has_exp);
    in_valid_i <= 1'b1;
    command_i <= c;
    first_operand_i <= a;
    second_operand_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7fffff)) - 32'sh400000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
    endcase
  endfunction

  // Random content; mostly valid commands, a few invalid ones
  task automatic send_random();
    logic [2:0] c;
    logic signed [31:0] a, b;
    vec_result_t none;
    none = mk(0, 0, 0, 0, 0);
    c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CmdBadLow, CmdBadHigh))
                                     : 3'($urandom_range(CmdLoadRect, CmdScale));
    a = rnd_val();
    b = rnd_val();
    if (c == CmdScale) begin
      // keep most scale factors near unity so the vector does not pin at the rails
      case ($urandom_range(0, 3))
        0: a = $urandom;
        default: a = $signed($urandom_range(0, 32'h3ffff)) - 32'sh10000;
      endcase
    end
    send_command(c, a, b, 0, none);
  endtask

  // Sender
  initial begin
    cmd_row_t rows[$];
    cur_x = 0; cur_y = 0; cur_mag = 0; cur_ang = 0;
    for (int i = 0; i < 31; i++)
      atan_tab[i] = ((atan_pico_val(i) / PicoDeg) << 16)
                    + (((atan_pico_val(i) % PicoDeg) << 16) + PicoDeg / 2) / PicoDeg;
    rows.push_back(row_exp(CmdNegate, 0, 0, mk(0, 0, 0, 0, 0)));
    rows.push_back(row_exp(CmdLoadRect, 0, 0, mk(0, 0, 0, 0, 0)));
    rows.push_back(row(CmdLoadRect, 32'sh10000, 0));
    rows.push_back(row(CmdLoadRect, 0, 32'sh10000));
    rows.push_back(row(CmdLoadRect, -32'sh10000, 0));
    rows.push_back(row(CmdLoadRect, -32'sh10000, -1));
    rows.push_back(row(CmdLoadRect, 32'sh7fffffff, 32'sh7fffffff));
    rows.push_back(row(CmdLoadRect, 32'sh80000000, 32'sh80000000));
    rows.push_back(row(CmdNegate, 0, 0));
    rows.push_back(row(CmdAdd, 32'sh7fffffff, 32'sh80000000));
    rows.push_back(row(CmdSub, 32'sh80000000, 32'sh7fffffff));
    rows.push_back(row(CmdScale, 32'sh7fffffff, 0));
    rows.push_back(row(CmdScale, 32'sh80000000, 0));
    rows.push_back(row(CmdLoadRect, 32'sh30000, -32'sh40000));
    rows.push_back(row(CmdScale, -32'sh8000, 0));
    rows.push_back(row_exp(CmdBadLow, 32'sh1234, 32'sh5678, mk(0, 0, 0, 0, 1)));
    rows.push_back(row_exp(CmdLoadPolar, -32'sh10000, 32'sh10000, mk(0, 0, 0, 0, 0)));
    rows.push_back(row_exp(CmdLoadPolar, 0, 0, mk(0, 0, 0, 0, 0)));
    rows.push_back(row(CmdLoadPolar, 32'sh10000, 180 * 65536));
    rows.push_back(row(CmdLoadPolar, 32'sh10000, -180 * 65536));
    rows.push_back(row(CmdLoadPolar, 32'sh20000, 540 * 65536 + 7));
    rows.push_back(row(CmdLoadPolar, 32'sh7fffffff, 32'sh7fffffff));
    rows.push_back(row(CmdLoadPolar, 32'sh7fffffff, 32'sh80000000));
    rows.push_back(row(CmdLoadPolar, 32'sh50000, 135 * 65536));
    rows.push_back(row_exp(CmdBadHigh, 32'sh7fffffff, 32'sh80000000, mk(0, 0, 0, 0, 1)));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i])
      send_command(rows[i].cmd, rows[i].a, rows[i].b, rows[i].has_exp, rows[i].res);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        // drain: hold off until every pending result is back
        in_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      if (n == NumRandom - 60) quiet = 1;
      send_random();
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    vec_result_t e, h;
    bit hv, bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result x=%0d", x_out_o);
      end else begin
        e = pending_q.pop_front();
        h = hand_q.pop_front();
        hv = hand_valid_q.pop_front();
        if (hv && ((h.x !== e.x) || (h.y !== e.y) || (h.mag !== e.mag) ||
                   (h.ang !== e.ang) || (h.bad !== e.bad))) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: predictor disagrees with table row x=%0d/%0d", e.x, h.x);
        end
        bad = (x_out_o !== e.x) || (y_out_o !== e.y) || (magnitude_out_o !== e.mag) ||
              (angle_out_o !== e.ang) || (bad_command_o !== e.bad);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp x=%0d y=%0d m=%0d a=%0d b=%0b got x=%0d y=%0d m=%0d a=%0d b=%0b",
                     e.x, e.y, e.mag, e.ang, e.bad, x_out_o, y_out_o, magnitude_out_o,
                     angle_out_o, bad_command_o);
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vrpa_pkg.sv
hw/rtl/vrpa_ctrl.sv
hw/rtl/vrpa_datapath.sv
hw/rtl/vector_rect_polar_accumulator.sv
tb/vector_rect_polar_accumulator_tb.sv
